>>> src/efd_pkg.sv
// Shared types, codes and tag table for the encapsulated fragment deframer.
`timescale 1ns / 1ps
`default_nettype none

package efd_pkg;

    // Input item kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Final status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_MULTI = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd3;

    // Item tag bytes in stream order
    localparam logic [7:0] TAG_BYTE0 = 8'hFE;
    localparam logic [7:0] TAG_BYTE1 = 8'hFF;
    localparam logic [7:0] TAG_BYTE2 = 8'h00;
    localparam logic [7:0] TAG_BYTE3 = 8'hE0;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic        is_status;
        logic [7:0]  payload_byte;
        logic [1:0]  status;
        logic [31:0] total_bytes;
        logic [15:0] fragment_count;
        logic        last;
    } t_out_item;

    // Result of one input transaction toward the output buffer
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_result;

    // Expected tag byte at a header position
    function automatic logic [7:0] tag_byte(input logic [1:0] pos);
        logic [7:0] b;
        unique case (pos)
            2'd0:    b = TAG_BYTE0;
            2'd1:    b = TAG_BYTE1;
            2'd2:    b = TAG_BYTE2;
            default: b = TAG_BYTE3;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> src/efd_parser.sv
// Header parser and fragment accounting state of the deframer.
`timescale 1ns / 1ps
`default_nettype none

module efd_parser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_take,
    input  wire efd_pkg::t_in_item i_item,
    output efd_pkg::t_result      o_result
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_STOPPED
    } t_phase;

    t_phase      r_phase,        n_phase;
    logic [2:0]  r_header_index, n_header_index;
    logic [31:0] r_length_shift, n_length_shift;
    logic [31:0] r_remaining,    n_remaining;
    logic [31:0] r_total,        n_total;
    logic [15:0] r_frags,        n_frags;
    logic        r_overflowed,   n_overflowed;

    logic [7:0]  w_byte;
    logic [31:0] w_len;
    logic [32:0] w_sum;
    logic [31:0] w_remaining_dec;

    assign w_byte = i_item.data_byte;
    // Complete length once the top byte arrives
    assign w_len  = r_length_shift | {w_byte, 24'd0};
    assign w_sum  = {1'b0, r_total} + {1'b0, w_len};
    assign w_remaining_dec = (r_remaining != 32'd0) ? (r_remaining - 32'd1) : r_remaining;

    // Next state and result for one transaction
    always_comb begin
        n_phase        = r_phase;
        n_header_index = r_header_index;
        n_length_shift = r_length_shift;
        n_remaining    = r_remaining;
        n_total        = r_total;
        n_frags        = r_frags;
        n_overflowed   = r_overflowed;
        o_result       = '0;

        if (i_item.kind == efd_pkg::KIND_END) begin
            o_result.valid               = 1'b1;
            o_result.item.is_status      = 1'b1;
            o_result.item.total_bytes    = r_total;
            o_result.item.fragment_count = r_frags;
            o_result.item.last           = 1'b1;
            priority if (r_overflowed) begin
                o_result.item.status = efd_pkg::STATUS_OVERFLOW;
            end else if (r_phase == PH_PAYLOAD && r_remaining != 32'd0) begin
                o_result.item.status = efd_pkg::STATUS_TRUNCATED;
            end else if (r_frags <= 16'd1 || r_total == 32'd0) begin
                o_result.item.status = efd_pkg::STATUS_NOT_MULTI;
            end else begin
                o_result.item.status = efd_pkg::STATUS_OK;
            end
            // Start a fresh stream
            n_phase        = PH_HEADER;
            n_header_index = 3'd0;
            n_length_shift = 32'd0;
            n_remaining    = 32'd0;
            n_total        = 32'd0;
            n_frags        = 16'd0;
            n_overflowed   = 1'b0;
        end else begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (!r_header_index[2]) begin
                        // Check tag byte, stop parsing on mismatch
                        if (w_byte != efd_pkg::tag_byte(r_header_index[1:0])) begin
                            n_phase        = PH_STOPPED;
                            n_header_index = 3'd0;
                            n_length_shift = 32'd0;
                        end else begin
                            n_header_index = r_header_index + 3'd1;
                        end
                    end else if (r_header_index != 3'd7) begin
                        // Gather little-endian length
                        n_length_shift = r_length_shift |
                            ({24'd0, w_byte} << {r_header_index[1:0], 3'b000});
                        n_header_index = r_header_index + 3'd1;
                    end else begin
                        // Close the header and account for the fragment
                        if (r_frags != efd_pkg::COUNT_MAX) begin
                            n_frags = r_frags + 16'd1;
                        end
                        if (w_sum[32]) begin
                            n_total      = efd_pkg::TOTAL_MAX;
                            n_overflowed = 1'b1;
                        end else begin
                            n_total = w_sum[31:0];
                        end
                        n_header_index = 3'd0;
                        n_length_shift = 32'd0;
                        if (w_len == 32'd0) begin
                            n_phase = PH_HEADER;
                        end else begin
                            n_remaining = w_len;
                            n_phase     = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    // Pass the byte through
                    o_result.valid             = 1'b1;
                    o_result.item.payload_byte = w_byte;
                    n_remaining                = w_remaining_dec;
                    if (w_remaining_dec == 32'd0) begin
                        n_phase = PH_HEADER;
                    end
                end
                default: begin
                    // Drop bytes until end of stream
                end
            endcase
        end

        if (!i_take) begin
            o_result.valid = 1'b0;
        end
    end

    // Hold parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEADER;
            r_header_index <= 3'd0;
            r_length_shift <= 32'd0;
            r_remaining    <= 32'd0;
            r_total        <= 32'd0;
            r_frags        <= 16'd0;
            r_overflowed   <= 1'b0;
        end else if (i_take) begin
            r_phase        <= n_phase;
            r_header_index <= n_header_index;
            r_length_shift <= n_length_shift;
            r_remaining    <= n_remaining;
            r_total        <= n_total;
            r_frags        <= n_frags;
            r_overflowed   <= n_overflowed;
        end
    end

endmodule

`default_nettype wire

>>> src/efd_out_buf.sv
// Result register with a skid entry for the deframer output channel.
`timescale 1ns / 1ps
`default_nettype none

module efd_out_buf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire efd_pkg::t_result  i_result,
    output logic                   o_full,
    output logic                   o_valid,
    output efd_pkg::t_out_item     o_item,
    input  wire logic              i_stall
);

    logic               r_main_valid;
    logic               r_skid_valid;
    efd_pkg::t_out_item r_main;
    efd_pkg::t_out_item r_skid;
    logic               w_pop;

    assign w_pop   = r_main_valid && !i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_item  = r_main;

    // Advance control: drain skid first, else load or park new result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_result.valid) begin
            if (r_main_valid && !w_pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_main_valid <= 1'b0;
        end
    end

    // Move payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_main <= r_skid;
            end
        end else if (i_result.valid) begin
            if (r_main_valid && !w_pop) begin
                r_skid <= i_result.item;
            end else begin
                r_main <= i_result.item;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/encapsulated_fragment_deframer_core.sv
// Results are registered in the output buffer before they appear on o_valid.
// Throughput: one byte per cycle while o_stall is low; the parser state updates in the accepting cycle.
// A two-entry output buffer keeps input flowing while a result waits for the sink.
// Reset: synchronous active-low i_rst_n returns the parser to header phase with
// zero counts and empties the output buffer.
// Top level of the encapsulated fragment deframer.
`timescale 1ns / 1ps
`default_nettype none

module encapsulated_fragment_deframer_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire efd_pkg::t_in_item  i_item,
    output logic                    o_stall,
    output logic                    o_valid,
    output efd_pkg::t_out_item      o_item,
    input  wire logic               i_stall
);

    logic             w_take;
    logic             w_full;
    efd_pkg::t_result w_result;

    // Accept while the skid entry is free
    assign o_stall = w_full;
    assign w_take  = i_valid && !w_full;

    efd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_take),
        .i_item   (i_item),
        .o_result (w_result)
    );

    efd_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (w_result),
        .o_full   (w_full),
        .o_valid  (o_valid),
        .o_item   (o_item),
        .i_stall  (i_stall)
    );

endmodule

`default_nettype wire
